/* src/sfcs_pkg.sv */
// Shared types, codes and sizes of the SPI flash command sequencer.
`timescale 1ns / 1ps
package sfcs_pkg;

    localparam int ADDR_W     = 32;
    localparam int LEN_W      = 25;
    localparam int POLL_W     = 11;
    localparam int FUNC_W     = 4;
    localparam int BYTE_W     = 8;
    localparam int STAT_W     = 3;
    localparam int PHASE_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MAX_RES    = 6;
    localparam int FRAME_MAX  = 5;
    localparam int RES_CNT_W  = 3;

    localparam int PAGE_BYTES   = 256;
    localparam int SECTOR_BYTES = 4096;
    localparam int PAGE_BITS    = $clog2(PAGE_BYTES);
    localparam int SECTOR_BITS  = $clog2(SECTOR_BYTES);
    localparam int ROOM_W       = PAGE_BITS + 1;

    localparam int SEC_OFS_W = 12;
    localparam logic [SEC_OFS_W-1:0] SEC_OFS_MAX = 12'h0FF;

    localparam int BUSY_BIT = 0;
    localparam logic [POLL_W-1:0] POLL_LIMIT_RST = 11'd1000;

    localparam logic [FUNC_W-1:0] FUNC_READ     = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE    = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_ERASE    = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_SEC_READ = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_WAKEUP   = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_SLEEP    = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_EN4B     = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_STATUS   = 4'd8;

    localparam logic [BYTE_W-1:0] OP_PROGRAM  = 8'h02;
    localparam logic [BYTE_W-1:0] OP_READ     = 8'h03;
    localparam logic [BYTE_W-1:0] OP_RDSR     = 8'h05;
    localparam logic [BYTE_W-1:0] OP_WREN     = 8'h06;
    localparam logic [BYTE_W-1:0] OP_SE       = 8'h20;
    localparam logic [BYTE_W-1:0] OP_SEC_READ = 8'h48;
    localparam logic [BYTE_W-1:0] OP_WAKEUP   = 8'hAB;
    localparam logic [BYTE_W-1:0] OP_SLEEP    = 8'hB9;
    localparam logic [BYTE_W-1:0] OP_EN4B     = 8'hB7;
    localparam logic [BYTE_W-1:0] DUMMY_BYTE  = 8'h00;

    localparam logic [STAT_W-1:0] ST_PROGRESS = 3'd0;
    localparam logic [STAT_W-1:0] ST_OK       = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVALID  = 3'd2;
    localparam logic [STAT_W-1:0] ST_TIMEOUT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_REJECTED = 3'd4;

    localparam logic [PHASE_W-1:0] PH_NONE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RX   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_TX   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 2'd1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_WRITE,
        MODE_ERASE
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_EMPTY,
        ACT_POLL,
        ACT_READ,
        ACT_SEC_READ,
        ACT_SINGLE,
        ACT_ISSUE
    } act_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]             count;
        logic                             empty;
        logic [MAX_RES-1:0]               fend;
        logic [MAX_RES-1:0][BYTE_W-1:0]   bytes;
        logic [PHASE_W-1:0]               phase;
        logic [LEN_W-1:0]                 data_count;
        logic [STAT_W-1:0]                status;
    } plan_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  spi_byte;
        logic               byte_valid;
        logic               frame_end;
        logic [PHASE_W-1:0] data_phase;
        logic [LEN_W-1:0]   data_count;
        logic [STAT_W-1:0]  status;
        logic               last;
    } res_t;

endpackage

/* src/sfcs_ctrl.sv */
// Request decode, operation state, configuration registers and result plan.
`timescale 1ns / 1ps
module sfcs_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [sfcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             take,
    input  logic [sfcs_pkg::FUNC_W-1:0]      func,
    input  logic [sfcs_pkg::ADDR_W-1:0]      address,
    input  logic [sfcs_pkg::LEN_W-1:0]       length,
    input  logic [sfcs_pkg::BYTE_W-1:0]      status_byte,
    output logic                             plan_load,
    output sfcs_pkg::plan_t                  plan
);
    import sfcs_pkg::*;

    logic                four_byte_reg;
    logic [POLL_W-1:0]   poll_limit_reg;
    mode_t               mode_reg, mode_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;
    logic [LEN_W-1:0]    rem_reg, rem_next;
    logic [POLL_W-1:0]   polls_reg, polls_next;

    act_t                act;
    logic [STAT_W-1:0]   res_status;

    logic                from_req;
    logic                iss_write;
    logic [ADDR_W-1:0]   iss_addr;
    logic [LEN_W-1:0]    iss_rem;
    logic [ROOM_W-1:0]   room;
    logic [LEN_W-1:0]    room_len;
    logic [LEN_W-1:0]    sector_len;
    logic [LEN_W-1:0]    chunk;
    logic [SEC_OFS_W-1:0] sec_end;
    logic                sec_bad;
    logic                misaligned;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_byte_reg  <= 1'b0;
            poll_limit_reg <= POLL_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_FOUR_BYTE)
                four_byte_reg <= cfg_data[0];
            else if (cfg_index == CFG_POLL_LIMIT)
                poll_limit_reg <= cfg_data[POLL_W-1:0];
        end
    end

    // next page or sector
    always_comb
    begin
        from_req   = (mode_reg == MODE_IDLE);
        iss_write  = from_req ? (func == FUNC_WRITE) : (mode_reg == MODE_WRITE);
        iss_addr   = from_req ? address : cur_reg;
        iss_rem    = from_req ? length : rem_reg;
        room       = ROOM_W'(PAGE_BYTES) - {1'b0, iss_addr[PAGE_BITS-1:0]};
        room_len   = LEN_W'(room);
        sector_len = LEN_W'(SECTOR_BYTES);
        if (iss_write)
            chunk = (iss_rem < room_len) ? iss_rem : room_len;
        else
            chunk = (iss_rem < sector_len) ? iss_rem : sector_len;
        sec_end    = address[SEC_OFS_W-1:0] + length[SEC_OFS_W-1:0];
        sec_bad    = (sec_end > SEC_OFS_MAX);
        misaligned = (address[SECTOR_BITS-1:0] != '0) || (length[SECTOR_BITS-1:0] != '0);
    end

    // next state
    always_comb
    begin
        act        = ACT_NONE;
        res_status = ST_PROGRESS;
        mode_next  = mode_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        polls_next = polls_reg;
        if (take)
        begin
            if (func > FUNC_STATUS)
            begin
                act        = ACT_EMPTY;
                res_status = ST_INVALID;
            end
            else if (func == FUNC_TICK || func == FUNC_STATUS)
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    if (func == FUNC_TICK)
                    begin
                        if (polls_reg == '0)
                        begin
                            mode_next  = MODE_IDLE;
                            act        = ACT_EMPTY;
                            res_status = ST_TIMEOUT;
                        end
                        else
                        begin
                            polls_next = polls_reg - POLL_W'(1);
                            act        = ACT_POLL;
                        end
                    end
                    else if (!status_byte[BUSY_BIT])
                    begin
                        if (rem_reg == '0)
                        begin
                            mode_next  = MODE_IDLE;
                            act        = ACT_EMPTY;
                            res_status = ST_OK;
                        end
                        else
                            act = ACT_ISSUE;
                    end
                    else if (polls_reg == '0)
                    begin
                        mode_next  = MODE_IDLE;
                        act        = ACT_EMPTY;
                        res_status = ST_TIMEOUT;
                    end
                    else
                        act = ACT_EMPTY;
                end
            end
            else if (mode_reg != MODE_IDLE)
            begin
                act        = ACT_EMPTY;
                res_status = ST_REJECTED;
            end
            else
            begin
                unique case (func) inside
                    FUNC_READ:
                    begin
                        act        = ACT_READ;
                        res_status = ST_OK;
                    end
                    FUNC_WRITE:
                    begin
                        if (length == '0)
                        begin
                            act        = ACT_EMPTY;
                            res_status = ST_OK;
                        end
                        else
                        begin
                            mode_next = MODE_WRITE;
                            act       = ACT_ISSUE;
                        end
                    end
                    FUNC_ERASE:
                    begin
                        if (misaligned)
                        begin
                            act        = ACT_EMPTY;
                            res_status = ST_INVALID;
                        end
                        else if (length == '0)
                        begin
                            act        = ACT_EMPTY;
                            res_status = ST_OK;
                        end
                        else
                        begin
                            mode_next = MODE_ERASE;
                            act       = ACT_ISSUE;
                        end
                    end
                    FUNC_SEC_READ:
                    begin
                        act        = sec_bad ? ACT_EMPTY : ACT_SEC_READ;
                        res_status = sec_bad ? ST_INVALID : ST_OK;
                    end
                    FUNC_WAKEUP, FUNC_SLEEP, FUNC_EN4B:
                    begin
                        act        = ACT_SINGLE;
                        res_status = ST_OK;
                    end
                    default:
                    begin
                        act        = ACT_EMPTY;
                        res_status = ST_INVALID;
                    end
                endcase
            end
            if (act == ACT_ISSUE)
            begin
                cur_next   = iss_addr + ADDR_W'(chunk);
                rem_next   = iss_rem - chunk;
                polls_next = poll_limit_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            cur_reg   <= '0;
            rem_reg   <= '0;
            polls_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
            polls_reg <= polls_next;
        end
    end

    // result plan
    always_comb
    begin
        logic                            we;
        logic                            single;
        logic                            four;
        logic                            dummy;
        logic [BYTE_W-1:0]               cmd;
        logic [ADDR_W-1:0]               adr;
        logic [FRAME_MAX-1:0][BYTE_W-1:0] fb;
        logic [RES_CNT_W-1:0]            flen;

        we     = 1'b0;
        single = 1'b0;
        four   = four_byte_reg;
        dummy  = 1'b0;
        cmd    = OP_READ;
        adr    = address;
        plan   = '0;
        plan.status = res_status;

        unique case (act)
            ACT_POLL:
            begin
                single          = 1'b1;
                cmd             = OP_RDSR;
                plan.phase      = PH_RX;
                plan.data_count = LEN_W'(1);
            end
            ACT_READ:
            begin
                plan.phase      = (length != '0) ? PH_RX : PH_NONE;
                plan.data_count = length;
            end
            ACT_SEC_READ:
            begin
                cmd             = OP_SEC_READ;
                four            = 1'b0;
                dummy           = 1'b1;
                plan.phase      = (length != '0) ? PH_RX : PH_NONE;
                plan.data_count = length;
            end
            ACT_SINGLE:
            begin
                single = 1'b1;
                case (func)
                    FUNC_WAKEUP: cmd = OP_WAKEUP;
                    FUNC_SLEEP:  cmd = OP_SLEEP;
                    default:     cmd = OP_EN4B;
                endcase
            end
            ACT_ISSUE:
            begin
                we  = 1'b1;
                adr = iss_addr;
                if (iss_write)
                begin
                    cmd             = OP_PROGRAM;
                    plan.phase      = PH_TX;
                    plan.data_count = chunk;
                end
                else
                    cmd = OP_SE;
            end
            default:
            begin
            end
        endcase

        fb    = '0;
        fb[0] = cmd;
        if (single)
            flen = RES_CNT_W'(1);
        else if (four)
        begin
            fb[1] = adr[31:24];
            fb[2] = adr[23:16];
            fb[3] = adr[15:8];
            fb[4] = adr[7:0];
            flen  = RES_CNT_W'(5);
        end
        else
        begin
            fb[1] = adr[23:16];
            fb[2] = adr[15:8];
            fb[3] = adr[7:0];
            fb[4] = DUMMY_BYTE;
            flen  = dummy ? RES_CNT_W'(5) : RES_CNT_W'(4);
        end

        if (act == ACT_EMPTY)
        begin
            plan.count = RES_CNT_W'(1);
            plan.empty = 1'b1;
        end
        else
        begin
            if (we)
            begin
                plan.bytes[0]   = OP_WREN;
                plan.bytes[5:1] = fb;
                plan.fend[0]    = 1'b1;
            end
            else
                plan.bytes[4:0] = fb;
            plan.count = flen + RES_CNT_W'(we);
            plan.fend[plan.count - RES_CNT_W'(1)] = 1'b1;
        end
    end

    assign plan_load = (act != ACT_NONE);

endmodule

/* src/sfcs_emit.sv */
// Plan register and result register: walk one request's bytes to the output.
`timescale 1ns / 1ps
module sfcs_emit (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             plan_load,
    input  sfcs_pkg::plan_t  plan,
    output logic             full,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output sfcs_pkg::res_t   res
);
    import sfcs_pkg::*;

    plan_t                plan_reg;
    logic                 plan_valid_reg, plan_valid_next;
    logic [RES_CNT_W-1:0] idx_reg, idx_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    res_t                 res_reg, res_next;
    logic                 out_free;
    logic                 emit;
    logic                 at_end;
    logic                 consume;

    always_comb
    begin
        out_free = !rsp_valid_reg || !rsp_stall;
        emit     = plan_valid_reg && out_free;
        at_end   = (idx_reg == plan_reg.count - RES_CNT_W'(1));
        consume  = emit && at_end;
        full     = plan_valid_reg && !consume;

        plan_valid_next = plan_valid_reg;
        idx_next        = idx_reg;
        if (plan_load)
        begin
            plan_valid_next = 1'b1;
            idx_next        = '0;
        end
        else if (consume)
        begin
            plan_valid_next = 1'b0;
            idx_next        = '0;
        end
        else if (emit)
            idx_next = idx_reg + RES_CNT_W'(1);

        if (emit)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;

        res_next            = '0;
        res_next.spi_byte   = plan_reg.bytes[idx_reg];
        res_next.byte_valid = !plan_reg.empty;
        res_next.frame_end  = plan_reg.fend[idx_reg];
        res_next.last       = at_end;
        if (at_end)
        begin
            res_next.data_phase = plan_reg.phase;
            res_next.data_count = plan_reg.data_count;
            res_next.status     = plan_reg.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            plan_valid_reg <= plan_valid_next;
            idx_reg        <= idx_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (plan_load)
            plan_reg <= plan;
        if (emit)
            res_reg <= res_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign res       = res_reg;

endmodule

/* src/spi_flash_command_sequencer_top.sv */
// Top level of the SPI NOR flash command sequencer.
//
//   channel  handshake               payload
//   request  req_valid / req_stall   func, address, length, status_byte
//   result   rsp_valid / rsp_stall   spi_byte .. last, one header byte each
//   config   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request is decoded in the cycle it is taken and its plan is registered;
// results then leave one per cycle unless stalled; a request gives 1 to 6
// results, holding requests until the last one; an idle tick gives none.
// Reset is asynchronous and leaves the block idle with no result pending.
// A stalled result holds the plan register, which then stalls requests.
`timescale 1ns / 1ps
module spi_flash_command_sequencer_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  logic [sfcs_pkg::FUNC_W-1:0]      func,
    input  logic [sfcs_pkg::ADDR_W-1:0]      address,
    input  logic [sfcs_pkg::LEN_W-1:0]       length,
    input  logic [sfcs_pkg::BYTE_W-1:0]      status_byte,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [sfcs_pkg::BYTE_W-1:0]      spi_byte,
    output logic                             byte_valid,
    output logic                             frame_end,
    output logic [sfcs_pkg::PHASE_W-1:0]     data_phase,
    output logic [sfcs_pkg::LEN_W-1:0]       data_count,
    output logic [sfcs_pkg::STAT_W-1:0]      status,
    output logic                             last,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfcs_pkg::*;

    logic  take;
    logic  full;
    logic  plan_load;
    plan_t plan;
    res_t  res;

    assign req_stall = full;
    assign take      = req_valid && !full;
    assign cfg_ready = 1'b1;

    sfcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .take        (take),
        .func        (func),
        .address     (address),
        .length      (length),
        .status_byte (status_byte),
        .plan_load   (plan_load),
        .plan        (plan)
    );

    sfcs_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .plan_load (plan_load),
        .plan      (plan),
        .full      (full),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .res       (res)
    );

    assign spi_byte   = res.spi_byte;
    assign byte_valid = res.byte_valid;
    assign frame_end  = res.frame_end;
    assign data_phase = res.data_phase;
    assign data_count = res.data_count;
    assign status     = res.status;
    assign last       = res.last;

endmodule

/* src/sfcs_checker.sv */
// Port-level checks of the command sequencer, bound to the top level.
`timescale 1ns / 1ps
module sfcs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             rsp_valid,
    input logic                             rsp_stall,
    input logic [sfcs_pkg::BYTE_W-1:0]      spi_byte,
    input logic                             byte_valid,
    input logic                             frame_end,
    input logic [sfcs_pkg::PHASE_W-1:0]     data_phase,
    input logic [sfcs_pkg::LEN_W-1:0]       data_count,
    input logic [sfcs_pkg::STAT_W-1:0]      status,
    input logic                             last
);
    import sfcs_pkg::*;

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(spi_byte) && $stable(last))
        else $error("result dropped or changed while stalled");

    // drop outcome from all but the final result of a request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> status == ST_PROGRESS && data_phase == PH_NONE)
        else $error("outcome or data phase on a result that is not last");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !byte_valid |-> last && !frame_end && spi_byte == '0)
        else $error("empty result is not a lone final result");

    a_count_phase: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && data_phase == PH_NONE |-> data_count == '0)
        else $error("data count without a data phase");

    a_phase_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && data_phase != PH_NONE |-> frame_end && byte_valid)
        else $error("data phase outside a frame end");

endmodule

bind spi_flash_command_sequencer_top sfcs_checker u_sfcs_checker (.*);
